### rtl/thbt_pkg.sv
// ----------------------------------------------------------------------------
// thbt_pkg
// Types and constants shared by the timed host block table.
// ----------------------------------------------------------------------------
package thbt_pkg;

	localparam int IP_W   = 32;
	localparam int PORT_W = 16;
	localparam int MS_W   = 20;
	localparam int OP_W   = 2;

	// APB register map
	localparam int APB_DW = 32;
	localparam int APB_AW = 3;
	localparam logic ADDR_BLOCK_DURATION = 1'b0;	// word select, paddr[2]

	localparam logic [MS_W-1:0] BLOCK_MS_RESET = MS_W'(30000);

	// op codes; code 3 is unused and does nothing
	localparam logic [OP_W-1:0] OP_KICK  = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IP_W-1:0]   ip_address;
		logic [PORT_W-1:0] port_number;
		logic [MS_W-1:0]   elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic is_blocked;
		logic insert_dropped;
	} out_item_t;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic [MS_W-1:0]   remaining_ms;
	} entry_t;

	typedef struct packed {
		logic   rd_en;
		logic   wr_en;
		entry_t wdata;
	} mem_req_t;

	typedef struct packed {
		logic      idle;
		logic      done;
		out_item_t result;
	} walk_status_t;

	typedef enum logic [1:0] {
		WS_IDLE,
		WS_SCAN,
		WS_DRAIN,
		WS_DONE
	} walk_state_t;

endpackage

### rtl/thbt_mem.sv
// ----------------------------------------------------------------------------
// thbt_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module thbt_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  thbt_pkg::mem_req_t req,
	input  logic [AW-1:0]     waddr,
	input  logic [AW-1:0]     raddr,
	output thbt_pkg::entry_t   rdata
);
	import thbt_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/thbt_walk.sv
// ----------------------------------------------------------------------------
// thbt_walk
// Sequencer: walks the table one entry per cycle, holds the valid bits and
// does the read-modify-write of the entry memory.
// ----------------------------------------------------------------------------
module thbt_walk #(
	parameter int ENTRIES = 16,
	parameter int IW      = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  thbt_pkg::in_item_t         in_item,
	input  logic [thbt_pkg::MS_W-1:0]  block_duration_ms,
	input  logic                       res_ready,
	output thbt_pkg::walk_status_t     status,
	output thbt_pkg::mem_req_t         mem_req,
	output logic [IW-1:0]              mem_waddr,
	output logic [IW-1:0]              mem_raddr,
	input  thbt_pkg::entry_t           mem_rdata
);
	import thbt_pkg::*;

	walk_state_t          state_q, state_d;
	in_item_t             cmd_q, cmd_d;
	out_item_t            acc_q, acc_d;
	logic [IW-1:0]        idx_q, idx_d;
	logic [IW-1:0]        idx_s1, idx_s1_d;
	logic                 vld_s1, vld_s1_d;
	logic [ENTRIES-1:0]   valid_q;
	logic [IW-1:0]        vsel;
	logic                 vbit;
	logic                 v_set, v_clr;
	logic                 last;

	// kick scans the valid bits directly; query/tick look at them at stage 1
	assign vsel = vld_s1 ? idx_s1 : idx_q;
	assign vbit = valid_q[vsel];
	assign last = (idx_q == IW'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WS_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= vld_s1_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (v_set) begin
			valid_q[vsel] <= 1'b1;
		end else if (v_clr) begin
			valid_q[vsel] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		acc_q  <= acc_d;
		idx_q  <= idx_d;
		idx_s1 <= idx_s1_d;
	end

	always_comb begin
		state_d    = state_q;
		cmd_d      = cmd_q;
		acc_d      = acc_q;
		idx_d      = idx_q;
		idx_s1_d   = idx_s1;
		vld_s1_d   = 1'b0;
		v_set      = 1'b0;
		v_clr      = 1'b0;
		mem_req    = '0;
		mem_waddr  = idx_q;
		mem_raddr  = idx_q;
		status     = '0;
		status.result = acc_q;

		// stage 1: read data for idx_s1 is back
		if (vld_s1 && vbit) begin
			if (cmd_q.op == OP_QUERY) begin
				if (mem_rdata.ip == cmd_q.ip_address) begin
					acc_d.is_blocked = 1'b1;
				end
			end else if (mem_rdata.remaining_ms < cmd_q.elapsed_ms) begin
				v_clr = 1'b1;
			end else begin
				mem_req.wr_en              = 1'b1;
				mem_waddr                  = idx_s1;
				mem_req.wdata.ip           = mem_rdata.ip;
				mem_req.wdata.port         = mem_rdata.port;
				mem_req.wdata.remaining_ms = mem_rdata.remaining_ms - cmd_q.elapsed_ms;
			end
		end

		case (state_q)
			WS_IDLE: begin
				status.idle = 1'b1;
				if (in_valid) begin
					cmd_d = in_item;
					acc_d = '0;
					idx_d = '0;
					if (in_item.op == OP_KICK || in_item.op == OP_QUERY ||
					    in_item.op == OP_TICK) begin
						state_d = WS_SCAN;
					end else begin
						state_d = WS_DONE;
					end
				end
			end
			WS_SCAN: begin
				if (cmd_q.op == OP_KICK) begin
					if (!vbit) begin
						v_set                      = 1'b1;
						mem_req.wr_en              = 1'b1;
						mem_req.wdata.ip           = cmd_q.ip_address;
						mem_req.wdata.port         = cmd_q.port_number;
						mem_req.wdata.remaining_ms = block_duration_ms;
						state_d                    = WS_DONE;
					end else if (last) begin
						acc_d.insert_dropped = 1'b1;
						state_d              = WS_DONE;
					end else begin
						idx_d = idx_q + IW'(1);
					end
				end else begin
					mem_req.rd_en = 1'b1;
					vld_s1_d      = 1'b1;
					idx_s1_d      = idx_q;
					if (last) begin
						state_d = WS_DRAIN;
					end else begin
						idx_d = idx_q + IW'(1);
					end
				end
			end
			WS_DRAIN: begin
				state_d = WS_DONE;
			end
			WS_DONE: begin
				if (res_ready) begin
					status.done = 1'b1;
					state_d     = WS_IDLE;
				end
			end
			default: begin
				state_d = WS_IDLE;
			end
		endcase
	end

endmodule

### rtl/timed_host_block_table.sv
// ----------------------------------------------------------------------------
// timed_host_block_table
// Table of blocked hosts with a per-entry countdown, APB duration register.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_stall and each gives exactly one result on
// out_valid/out_stall. A kick (op 0) stores address and port in the lowest
// free slot with the block duration from the APB register at byte 0 (20 bits,
// reset 30000 ms); with no free slot the kick is dropped and insert_dropped
// is set. A query (op 1) sets is_blocked when any live slot holds the same
// IPv4 address (port ignored). A tick (op 2) takes elapsed_ms off every live
// slot and frees those whose remaining time is below elapsed_ms, so a slot at
// exactly zero lasts one more tick. Op 3 does nothing and returns zeros.
// Sequencing: the sequencer walks the entries one per cycle through an entry
// memory with one read port and one write port. A kick stops at the first
// free slot, or at the last slot when the table is full; a query or tick
// reads every entry and then waits in a drain state for the last read; op 3
// goes straight to the result. While the result register holds a stalled
// result, the finished item waits in the sequencer and the input stays
// stalled. One item is in flight at a time; the finished result sits in an
// output register, so it may wait there while the next item is accepted.
// The entry valid bits are flops cleared by reset; no memory clear pass is
// needed.
// ----------------------------------------------------------------------------
module timed_host_block_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item input
	input  logic                          in_valid,
	output logic                          in_stall,
	input  thbt_pkg::in_item_t            in_item,
	// result output
	output logic                          out_valid,
	input  logic                          out_stall,
	output thbt_pkg::out_item_t           out_item,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [thbt_pkg::APB_AW-1:0]   paddr,
	input  logic [thbt_pkg::APB_DW-1:0]   pwdata,
	output logic [thbt_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import thbt_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);

	logic [MS_W-1:0] dur_q;
	logic            cfg_wr;
	logic            out_valid_q;
	out_item_t       out_item_q;
	logic            res_ready;
	walk_status_t    walk_st;
	mem_req_t        mem_req;
	logic [IW-1:0]   mem_waddr;
	logic [IW-1:0]   mem_raddr;
	entry_t          mem_rdata;

	// APB: pready is always high, word select on paddr[2]
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready &&
	                (paddr[2] == ADDR_BLOCK_DURATION);
	assign prdata = (paddr[2] == ADDR_BLOCK_DURATION) ? APB_DW'(dur_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_q <= BLOCK_MS_RESET;
		end else if (cfg_wr) begin
			dur_q <= pwdata[MS_W-1:0];
		end
	end

	// input is taken only while the sequencer is idle
	assign in_stall = !walk_st.idle;

	// result register: the sequencer hands over only when it is free or draining
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (walk_st.done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (walk_st.done) begin
			out_item_q <= walk_st.result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	thbt_walk #(
		.ENTRIES (TABLE_ENTRIES),
		.IW      (IW)
	) u_walk (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_item           (in_item),
		.block_duration_ms (dur_q),
		.res_ready         (res_ready),
		.status            (walk_st),
		.mem_req           (mem_req),
		.mem_waddr         (mem_waddr),
		.mem_raddr         (mem_raddr),
		.mem_rdata         (mem_rdata)
	);

	thbt_mem #(
		.DEPTH (TABLE_ENTRIES),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.waddr (mem_waddr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef SYNTHESIS
	// a handover never overwrites a result that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		walk_st.done |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten");

	// one item in flight: an accepted item stalls the input next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("second item accepted while busy");

	// a result never reports both a hit and a dropped insert
	a_result_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.is_blocked && out_item.insert_dropped))
		else $error("both result flags set");

	// the duration register takes the written value
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (dur_q == $past(pwdata[MS_W-1:0])))
		else $error("duration register write lost");
`endif

endmodule

### tb/sv/tb_timed_host_block_table.sv
// ----------------------------------------------------------------------------
// tb_timed_host_block_table
// Self-checking bench for the timed host block table.
// Drives kick, query, tick and unused-op items through the valid/stall input
// and keeps its own copy of the host table to predict each result.
// Starts with a table of directed items and then runs random phases, each
// under its own block duration written over APB. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_timed_host_block_table;
	import thbt_pkg::*;

	localparam int TABLE_ENTRIES = 16;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 200;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 30;
	localparam logic [OP_W-1:0]   OP_UNUSED     = 2'd3;
	localparam logic [APB_AW-1:0] DURATION_ADDR = {ADDR_BLOCK_DURATION, 2'b00};

	// one row of the directed table; a row may repeat its item and may set
	// a new block duration before it is sent (dur_ms < 0 leaves it alone)
	typedef struct {
		logic [OP_W-1:0]   op;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] port;
		logic [MS_W-1:0]   ms;
		int                reps;
		bit                typed;
		out_item_t         want;
		int                dur_ms;
	} dir_row_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// block ports; every input is driven from time zero
	logic                in_valid  = 1'b0;
	logic                in_stall;
	in_item_t            in_item   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	out_item_t           out_item;
	logic                psel      = 1'b0;
	logic                penable   = 1'b0;
	logic                pwrite    = 1'b0;
	logic [APB_AW-1:0]   paddr     = '0;
	logic [APB_DW-1:0]   pwdata    = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;

	timed_host_block_table #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// ------------------------------------------------------------------
	// Shadow host table: the bench's own view of every slot and of the
	// block duration register. Address, port and time of a slot are only
	// looked at while the slot is live.
	// ------------------------------------------------------------------
	bit                live      [TABLE_ENTRIES];
	logic [IP_W-1:0]   host_ip   [TABLE_ENTRIES];
	logic [PORT_W-1:0] host_port [TABLE_ENTRIES];
	logic [MS_W-1:0]   host_left [TABLE_ENTRIES];
	logic [MS_W-1:0]   block_ms  = BLOCK_MS_RESET;

	out_item_t verdict_q [$];	// verdicts owed by the block, oldest first
	dir_row_t  directed_rows [$];
	logic [IP_W-1:0] host_pool [8];

	int  n_fail     = 0;
	int  n_results  = 0;
	int  n_kicks    = 0;
	int  n_drops    = 0;
	int  n_queries  = 0;
	int  n_hits     = 0;
	int  n_ticks    = 0;
	int  n_unused   = 0;
	int  n_settings = 0;
	int  n_holds    = 0;
	int  calm_left  = 0;
	bit  hold_req   = 1'b0;

	task automatic report_mismatch(string what, logic [APB_DW-1:0] got,
			logic [APB_DW-1:0] want);
		n_fail++;
		$display("[%0t] MISMATCH %s: got %0h, want %0h", $realtime, what, got, want);
	endtask

	// Applies one item to the shadow table and returns the verdict it earns.
	function automatic out_item_t apply_host_op(in_item_t it);
		out_item_t v;
		bit        placed;
		v      = '0;
		placed = 1'b0;
		case (it.op)
			OP_KICK: begin
				// lowest free slot wins, duplicates are fine
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (!placed && !live[i]) begin
						live[i]      = 1'b1;
						host_ip[i]   = it.ip_address;
						host_port[i] = it.port_number;
						host_left[i] = block_ms;
						placed       = 1'b1;
					end
				end
				v.insert_dropped = !placed;
			end
			OP_QUERY: begin
				// address only, the port never takes part
				for (int i = 0; i < TABLE_ENTRIES; i++)
					if (live[i] && host_ip[i] == it.ip_address)
						v.is_blocked = 1'b1;
			end
			OP_TICK: begin
				// strictly less frees the slot, so zero left lasts one more tick
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (live[i]) begin
						if (host_left[i] < it.elapsed_ms)
							live[i] = 1'b0;
						else
							host_left[i] = host_left[i] - it.elapsed_ms;
					end
				end
			end
			default: ;	// unused code: no change, all zero
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// mostly back to back, some short gaps, a few long ones, and now and
	// then a run of items with no gap at all
	function automatic int pick_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			calm_left = $urandom_range(20, 60);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one item, holds it until accepted, then books its verdict.
	// Called at a rising edge; returns at the edge that took the item.
	task automatic send_item(in_item_t it, bit typed, out_item_t typed_want);
		int        gap;
		out_item_t want;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (in_stall);
		want = apply_host_op(it);
		case (it.op)
			OP_KICK: begin
				n_kicks++;
				n_drops += want.insert_dropped;
			end
			OP_QUERY: begin
				n_queries++;
				n_hits += want.is_blocked;
			end
			OP_TICK: n_ticks++;
			default: n_unused++;
		endcase
		// a typed row is held to its own value; the shadow still advances
		verdict_q.insert(verdict_q.size(), typed ? typed_want : want);
	endtask

	// Random item: mostly addresses from a small pool so kicks and queries
	// meet, and tick lengths placed around the current block duration.
	function automatic in_item_t random_request();
		in_item_t it;
		int       r;
		it.ip_address  = $urandom;
		it.port_number = PORT_W'($urandom);
		it.elapsed_ms  = MS_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 40)
			it.op = OP_KICK;
		else if (r < 75)
			it.op = OP_QUERY;
		else if (r < 95)
			it.op = OP_TICK;
		else
			it.op = OP_UNUSED;
		if ($urandom_range(0, 9) < 8)
			it.ip_address = host_pool[$urandom_range(0, 7)];
		if (it.op == OP_TICK) begin
			case ($urandom_range(0, 6))
				0: it.elapsed_ms = '0;
				1: it.elapsed_ms = block_ms;
				2: it.elapsed_ms = block_ms + 1'b1;
				3: it.elapsed_ms = MS_W'($urandom_range(0, int'(block_ms >> 2)));
				4: it.elapsed_ms = MS_W'($urandom_range(0, 50));
				default: ;	// keep the full-range value
			endcase
		end
		return it;
	endfunction

	// ------------------------------------------------------------------
	// APB access
	// ------------------------------------------------------------------
	task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data     = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Reads the duration register back and holds it to the shadow copy.
	task automatic check_block_ms();
		logic [APB_DW-1:0] rd;
		apb_read(DURATION_ADDR, rd);
		if (rd[MS_W-1:0] !== block_ms)
			report_mismatch("block duration readback", rd, APB_DW'(block_ms));
	endtask

	// Register writes only once the block has nothing in flight: every
	// item gives one verdict, so an empty queue plus a short pause is idle.
	task automatic set_block_ms(logic [MS_W-1:0] dur);
		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		// junk in the bits above the field, they must be dropped
		apb_write(DURATION_ADDR, {12'($urandom), dur});
		block_ms = dur;
		n_settings++;
		check_block_ms();
	endtask

	// ------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------
	function automatic void add_row(logic [OP_W-1:0] op, logic [IP_W-1:0] ip,
			logic [PORT_W-1:0] port, logic [MS_W-1:0] ms, int reps, bit typed,
			logic blocked, logic dropped, int dur_ms);
		dir_row_t r;
		r.op   = op;
		r.ip   = ip;
		r.port = port;
		r.ms   = ms;
		r.reps = reps;
		r.typed = typed;
		r.want.is_blocked     = blocked;
		r.want.insert_dropped = dropped;
		r.dur_ms = dur_ms;
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	initial begin
		//       op         ip            port      ms        reps typed blk drp dur
		// empty after reset
		add_row(OP_QUERY,  32'h0,        16'h0,    20'h0,     1,  1,    0,  0, -1);
		// unused code with every field at its top value
		add_row(OP_UNUSED, '1,           '1,       '1,        1,  1,    0,  0, -1);
		// extreme addresses and ports; elapsed is ignored on a kick
		add_row(OP_KICK,   32'h0,        16'h0,    '1,        1,  1,    0,  0, -1);
		add_row(OP_KICK,   '1,           '1,       20'h0,     1,  1,    0,  0, -1);
		add_row(OP_QUERY,  '1,           16'h0,    20'h0,     1,  1,    1,  0, -1);
		// port differs from the stored one, still a hit
		add_row(OP_QUERY,  32'h0,        16'h1234, 20'h0,     1,  1,    1,  0, -1);
		// zero-length tick changes nothing
		add_row(OP_TICK,   32'h0,        16'h0,    20'h0,     1,  1,    0,  0, -1);
		// fill the rest of the table with one duplicated host
		add_row(OP_KICK,   32'h0A000001, 16'd80,   20'h0,    14,  1,    0,  0, -1);
		// table full: dropped
		add_row(OP_KICK,   32'h0A000002, 16'd443,  20'h0,     1,  1,    0,  1, -1);
		// every slot goes to exactly zero and survives
		add_row(OP_TICK,   32'h0,        16'h0,    20'd30000, 1,  1,    0,  0, -1);
		add_row(OP_QUERY,  32'h0A000001, 16'h0,    20'h0,     1,  1,    1,  0, -1);
		// one more millisecond frees them all
		add_row(OP_TICK,   32'h0,        16'h0,    20'd1,     1,  1,    0,  0, -1);
		add_row(OP_QUERY,  32'h0A000001, 16'h0,    20'h0,     1,  1,    0,  0, -1);
		add_row(OP_KICK,   32'hC0A80001, 16'd22,   20'h0,     1,  0,    0,  0, -1);
		// zero block duration: lives through a zero tick, dies on any other
		add_row(OP_KICK,   32'h01020304, 16'd7,    20'h0,     1,  1,    0,  0,  0);
		add_row(OP_TICK,   32'h0,        16'h0,    20'h0,     1,  1,    0,  0, -1);
		add_row(OP_QUERY,  32'h01020304, 16'h0,    20'h0,     1,  1,    1,  0, -1);
		add_row(OP_TICK,   32'h0,        16'h0,    20'd1,     1,  1,    0,  0, -1);
		add_row(OP_QUERY,  32'h01020304, 16'h0,    20'h0,     1,  1,    0,  0, -1);
		// the host from before the duration change is still there
		add_row(OP_QUERY,  32'hC0A80001, 16'h0,    20'h0,     1,  0,    0,  0, -1);
	end

	// ------------------------------------------------------------------
	// Receiver side: stalls in random bursts; on request it holds off for
	// a long stretch so the result register fills and the input stalls.
	// ------------------------------------------------------------------
	initial begin : result_sink
		int run;
		int hold;
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				n_holds++;
			end else begin
				run = $urandom_range(1, 40);
				out_stall <= 1'b0;
				repeat (run) @(posedge clk);
				hold = $urandom_range(0, 99);
				if (hold < 50)
					hold = 0;
				else if (hold < 90)
					hold = $urandom_range(1, 3);
				else
					hold = $urandom_range(10, 50);
				if (hold > 0) begin
					out_stall <= 1'b1;
					repeat (hold) @(posedge clk);
				end
			end
		end
	end

	// Every result taken is held against the oldest verdict owed.
	always @(posedge clk) begin : verdict_check
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				report_mismatch("result with nothing outstanding", APB_DW'(out_item), '0);
			end else begin
				want = verdict_q.pop_front();
				n_results++;
				if (out_item.is_blocked !== want.is_blocked)
					report_mismatch("is_blocked", APB_DW'(out_item.is_blocked),
						APB_DW'(want.is_blocked));
				if (out_item.insert_dropped !== want.insert_dropped)
					report_mismatch("insert_dropped", APB_DW'(out_item.insert_dropped),
						APB_DW'(want.insert_dropped));
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		in_item_t          it;
		logic [MS_W-1:0]   phase_ms [PHASES];
		// pool of hosts, the all-zero and all-one addresses among them
		host_pool[0] = '0;
		host_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			host_pool[i] = $urandom;
		// duration per random phase: extremes first, then the default and
		// a couple of arbitrary values
		phase_ms[0] = '1;
		phase_ms[1] = '0;
		phase_ms[2] = MS_W'(1);
		phase_ms[3] = BLOCK_MS_RESET;
		phase_ms[4] = MS_W'($urandom_range(2, 5000));
		phase_ms[5] = MS_W'($urandom);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// register must come out of reset at its default
		check_block_ms();

		foreach (directed_rows[k]) begin
			if (directed_rows[k].dur_ms >= 0)
				set_block_ms(MS_W'(directed_rows[k].dur_ms));
			it.op          = directed_rows[k].op;
			it.ip_address  = directed_rows[k].ip;
			it.port_number = directed_rows[k].port;
			it.elapsed_ms  = directed_rows[k].ms;
			repeat (directed_rows[k].reps)
				send_item(it, directed_rows[k].typed, directed_rows[k].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			set_block_ms(phase_ms[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off while items keep coming
				if (p == 0 && n == 80)
					hold_req = 1'b1;
				send_item(random_request(), 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d kicks (%0d dropped), %0d queries (%0d hits), %0d ticks, %0d unused",
			n_kicks, n_drops, n_queries, n_hits, n_ticks, n_unused);
		$display("%0d results checked across %0d duration writes, %0d long output hold-offs",
			n_results, n_settings, n_holds);
		if (n_fail == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin : watchdog
		#2000000;
		$display("timeout with %0d verdicts outstanding", verdict_q.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
